### rtl/core/first_fit_pool_allocator_assert.svh
// Assertion macros for the pool allocator.
`ifndef FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_POOL_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFPA_AST_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);
`define FFPA_AST_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);
`else
`define FFPA_AST_IMPLY(label, clk, rst_n, a, b, msg)
`define FFPA_AST_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

### rtl/core/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

    localparam int DIV_W = 18;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [15:0] MIN_SPLIT_RESET = 16'd32;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Greatest common divisor of two positive constants, by repeated subtraction.
    function automatic int gcd(input int a, input int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) begin
                x = x - y;
            end else begin
                y = y - x;
            end
        end
        return x;
    endfunction

endpackage
`default_nettype wire

### rtl/core/ffpa_hdr_ram.sv
`default_nettype none
module ffpa_hdr_ram #(
    parameter int DEPTH = 8190,
    parameter int AW    = 13,
    parameter int DW    = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/ffpa_div.sv
`default_nettype none
module ffpa_div #(
    parameter int DIVISOR = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ffpa_pkg::DIV_W-1:0]    i_num,
    output logic      [ffpa_pkg::DIV_W-1:0]    o_quo,
    output ffpa_pkg::t_div_stat                o_stat
);
    localparam int W  = ffpa_pkg::DIV_W;
    localparam int SH = W + $clog2(DIVISOR);
    localparam longint unsigned MUL = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
    localparam int MW = $clog2(MUL + 1);
    localparam int PW = W + MW;

    logic [W-1:0]  r_num;
    logic          r_busy;
    logic          r_done;
    logic [PW-1:0] w_prod;

    // Reciprocal multiplication, exact for every W-bit numerator.
    assign w_prod = PW'(r_num) * PW'(MUL);

    // Register the numerator, then register the quotient in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_num <= i_num;
            end
            if (r_busy) begin
                o_quo <= W'(w_prod >> SH);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule
`default_nettype wire

### rtl/core/first_fit_pool_allocator.sv
// Allocate: take the request, round the size, read and check each cell walked,
// write a split cell if one is made, then load the result register.
// Free: take the request, walk the cells up to the target, read the next cell and merge
// (not for the last cell), then load the result; report: walk the chain, load the result.
// One request in flight; the result load waits while the previous result is untaken.
// Synchronous active-low reset rewrites the initial free cell and restores min_split to 32.
`default_nettype none
`include "first_fit_pool_allocator_assert.svh"
module first_fit_pool_allocator #(
    parameter int POOL_BYTES   = 65536,
    parameter int HEADER_BYTES = 8,
    parameter int ALIGN_BYTES  = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [16:0] i_request_size,
    input  wire logic [15:0] i_free_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_alloc_offset,
    output logic [16:0]      o_total_bytes,
    output logic [16:0]      o_used_bytes
);
    // Headers sit at their cell start, addressed in units of the common granule of
    // alignment and header size. The end marker is implied at END_U.
    localparam int GRAN   = ffpa_pkg::gcd(ALIGN_BYTES, HEADER_BYTES);
    localparam int POOL_R = (POOL_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int HU     = HEADER_BYTES / GRAN;
    localparam int AU     = ALIGN_BYTES / GRAN;
    localparam int END_U  = (POOL_R - HEADER_BYTES) / GRAN;
    localparam int INIT_U = (POOL_R - 2 * HEADER_BYTES) / GRAN;
    localparam int UW     = $clog2(END_U + 1);
    localparam int AW     = $clog2(END_U);
    localparam int DW     = UW + 1;
    localparam int PW     = $clog2(POOL_R + 1);
    localparam int XW     = ((PW > 16) ? PW : 16) + 1;
    localparam int NW     = ((UW > ffpa_pkg::DIV_W) ? UW : ffpa_pkg::DIV_W) + 1;
    localparam int QW     = ffpa_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_RD, S_CHK, S_NRD, S_MRG, S_WR2, S_DONE
    } t_state;

    t_state          r_state;
    logic [15:0]     r_min_split;
    logic [1:0]      r_mode;
    logic [15:0]     r_off;
    logic [NW-1:0]   r_need;
    logic [UW-1:0]   r_idx;
    logic [UW-1:0]   r_nidx;
    logic            r_has_next;
    logic [UW-1:0]   r_prev_idx;
    logic [DW-1:0]   r_prev_hdr;
    logic            r_prev_valid;
    logic [DW-1:0]   r_cur_hdr;
    logic [UW-1:0]   r_split_idx;
    logic [UW-1:0]   r_split_size;
    logic [PW-1:0]   r_free_sum;
    logic [1:0]      r_res_status;
    logic [15:0]     r_res_offset;
    logic [16:0]     r_res_total;
    logic [16:0]     r_res_used;

    logic            w_div_start;
    logic [QW-1:0]   w_div_num;
    logic [QW-1:0]   w_div_quo;
    ffpa_pkg::t_div_stat w_div;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [DW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [DW-1:0]   w_rdata;

    logic            w_used;
    logic [UW-1:0]   w_size;
    logic [UW:0]     w_next;
    logic            w_last;
    logic [XW-1:0]   w_pos_b;
    logic [NW-1:0]   w_rest;
    logic [XW-1:0]   w_rest_b;
    logic            w_fit;
    logic            w_split;
    logic [UW-1:0]   w_merge;
    logic [PW-1:0]   w_free_add;

    assign w_div_start = (r_state == S_IDLE) && i_valid && (i_mode == ffpa_pkg::MODE_ALLOC)
                         && (i_request_size != '0);
    assign w_div_num   = QW'(i_request_size) + QW'(ALIGN_BYTES - 1);

    ffpa_div #(.DIVISOR(ALIGN_BYTES)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_quo   (w_div_quo),
        .o_stat  (w_div)
    );

    ffpa_hdr_ram #(.DEPTH(END_U), .AW(AW), .DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Decode the header just read.
    assign w_used     = w_rdata[DW-1];
    assign w_size     = w_rdata[UW-1:0];
    assign w_next     = (UW + 1)'(r_idx) + (UW + 1)'(w_size) + (UW + 1)'(HU);
    assign w_last     = (w_next == (UW + 1)'(END_U));
    assign w_pos_b    = XW'(r_idx * GRAN);
    assign w_rest     = NW'(w_size) - r_need;
    assign w_rest_b   = XW'((w_rest - NW'(HU)) * GRAN);
    assign w_fit      = !w_used && (NW'(w_size) >= r_need);
    assign w_split    = (w_rest >= NW'(HU)) && (w_rest_b >= XW'(r_min_split));
    assign w_free_add = w_used ? '0 : PW'(w_size * GRAN);
    assign w_merge    = (r_has_next && !w_used) ?
                        (r_cur_hdr[UW-1:0] + w_size + UW'(HU)) : r_cur_hdr[UW-1:0];

    assign w_raddr = (r_state == S_NRD) ? r_nidx[AW-1:0] : r_idx[AW-1:0];

    // Write port: the initial cell during reset, else the walk's updates.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = '0;
        if (!i_rst_n) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {1'b0, UW'(INIT_U)};
        end else begin
            unique case (r_state)
                S_CHK: begin
                    if ((r_mode == ffpa_pkg::MODE_ALLOC) && w_fit) begin
                        w_we    = 1'b1;
                        w_wdata = {1'b1, w_split ? r_need[UW-1:0] : w_size};
                    end
                end
                S_MRG: begin
                    w_we = 1'b1;
                    if (r_prev_valid && !r_prev_hdr[DW-1]) begin
                        w_waddr = r_prev_idx[AW-1:0];
                        w_wdata = {1'b0, r_prev_hdr[UW-1:0] + w_merge + UW'(HU)};
                    end else begin
                        w_wdata = {1'b0, w_merge};
                    end
                end
                S_WR2: begin
                    w_we    = 1'b1;
                    w_waddr = r_split_idx[AW-1:0];
                    w_wdata = {1'b0, r_split_size};
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_split <= ffpa_pkg::MIN_SPLIT_RESET;
            o_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_split <= i_cfg_wdata;
            end
            // Drop the result once taken, unless a new one loads this cycle.
            if (o_valid && i_ready && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // Take the request and clear the result fields.
                        r_mode       <= i_mode;
                        r_off        <= i_free_offset;
                        r_idx        <= '0;
                        r_prev_valid <= 1'b0;
                        r_free_sum   <= '0;
                        r_res_offset <= '0;
                        r_res_total  <= '0;
                        r_res_used   <= '0;
                        priority if (i_mode == ffpa_pkg::MODE_ALLOC) begin
                            if (i_request_size == '0) begin
                                r_res_status <= ffpa_pkg::ST_FAIL;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= ffpa_pkg::ST_OK;
                                r_state      <= S_DIV;
                            end
                        end else if (i_mode == ffpa_pkg::MODE_FREE ||
                                     i_mode == ffpa_pkg::MODE_REPORT) begin
                            r_res_status <= ffpa_pkg::ST_OK;
                            r_state      <= S_RD;
                        end else begin
                            r_res_status <= ffpa_pkg::ST_FAIL;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_need  <= NW'(w_div_quo * AU);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    unique case (r_mode)
                        ffpa_pkg::MODE_ALLOC: begin
                            if (w_fit) begin
                                r_res_offset <= 16'(w_pos_b + XW'(HEADER_BYTES));
                                if (w_split) begin
                                    r_split_idx  <= UW'(NW'(r_idx) + r_need + NW'(HU));
                                    r_split_size <= UW'(w_rest - NW'(HU));
                                    r_state      <= S_WR2;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else if (w_last) begin
                                r_res_status <= ffpa_pkg::ST_FAIL;
                                r_state      <= S_DONE;
                            end else begin
                                r_idx   <= w_next[UW-1:0];
                                r_state <= S_RD;
                            end
                        end
                        ffpa_pkg::MODE_FREE: begin
                            if (w_pos_b + XW'(HEADER_BYTES) == XW'(r_off)) begin
                                r_cur_hdr  <= w_rdata;
                                r_nidx     <= w_next[UW-1:0];
                                r_has_next <= !w_last;
                                r_state    <= w_last ? S_MRG : S_NRD;
                            end else if (w_last) begin
                                r_res_status <= ffpa_pkg::ST_NOTFOUND;
                                r_state      <= S_DONE;
                            end else begin
                                r_prev_idx   <= r_idx;
                                r_prev_hdr   <= w_rdata;
                                r_prev_valid <= 1'b1;
                                r_idx        <= w_next[UW-1:0];
                                r_state      <= S_RD;
                            end
                        end
                        default: begin
                            // Report: total is the whole pool, used is what is not free.
                            r_free_sum <= r_free_sum + w_free_add;
                            if (w_last) begin
                                r_res_total <= 17'(POOL_R);
                                r_res_used  <= 17'(PW'(POOL_R) - r_free_sum - w_free_add);
                                r_state     <= S_DONE;
                            end else begin
                                r_idx   <= w_next[UW-1:0];
                                r_state <= S_RD;
                            end
                        end
                    endcase
                end
                S_NRD: begin
                    r_state <= S_MRG;
                end
                S_MRG: begin
                    r_state <= S_DONE;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_status       <= r_res_status;
                        o_alloc_offset <= r_res_offset;
                        o_total_bytes  <= r_res_total;
                        o_used_bytes   <= r_res_used;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FFPA_AST_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_valid && o_ready, r_state != S_IDLE, "request accepted but block stayed idle")
    `FFPA_AST_IMPLY(a_div_only_when_waiting, i_clk, i_rst_n, w_div.busy, r_state == S_DIV, "divider busy outside rounding state")
    `FFPA_AST_IMPLY(a_walk_in_range, i_clk, i_rst_n, r_state == S_CHK, r_idx < UW'(END_U), "walk index past end marker")
endmodule
`default_nettype wire
